[src/s360_subset_instruction_executor_top_assert.svh]
// assertion macros used by the executor module
`ifndef S360_SUBSET_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define S360_SUBSET_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define S360_ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define S360_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[src/s360x_pkg.sv]
`default_nettype none
package s360x_pkg;

  // opcodes
  localparam logic [7:0] OP_BALR = 8'h05;
  localparam logic [7:0] OP_BCR  = 8'h07;
  localparam logic [7:0] OP_ST   = 8'h50;
  localparam logic [7:0] OP_L    = 8'h58;
  localparam logic [7:0] OP_A    = 8'h5A;
  localparam logic [7:0] OP_S    = 8'h5B;

  localparam logic [3:0] MASK_ALWAYS = 4'hF;
  localparam logic [23:0] LOAD_BASE_RESET = 24'h800000;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXIT    = 2'd1;
  localparam logic [1:0] ST_BADMASK = 2'd2;
  localparam logic [1:0] ST_BADOP   = 2'd3;

  // one result item
  typedef struct packed {
    logic [9:0]  effective_address;
    logic        mem_written;
    logic [31:0] dest_value;
    logic [3:0]  dest_reg;
    logic        reg_written;
    logic [7:0]  opcode_done;
    logic [9:0]  next_pc;
    logic [1:0]  status;
  } res_t;

endpackage
`default_nettype wire

[src/s360x_ram.sv]
`default_nettype none
module s360x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/s360x_exec.sv]
`default_nettype none
module s360x_exec #(
  parameter int MEM_BYTES = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_op,
  input  wire logic [9:0]                   in_addr,
  input  wire logic [7:0]                   in_byte,
  input  wire logic [23:0]                  load_base,
  input  wire logic                         out_free,
  output logic                              res_valid,
  output s360x_pkg::res_t                   res,
  output logic                              mwe,
  output logic [$clog2(MEM_BYTES)-1:0]      mwaddr,
  output logic [7:0]                        mwdata,
  output logic [$clog2(MEM_BYTES)-1:0]      mraddr,
  input  wire logic [7:0]                   mrdata,
  output logic                              rwe,
  output logic [3:0]                        rwaddr,
  output logic [31:0]                       rwdata,
  output logic [3:0]                        rraddr,
  input  wire logic [31:0]                  rrdata
);

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_F0, S_F1, S_F2, S_F3, S_ADDR, S_MWR, S_MRD, S_MRDL, S_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr;
  logic [1:0]      cnt;
  logic [AW-1:0]   pc;
  logic            halted;
  logic [1:0]      halt_code;
  logic [7:0]      opc;
  logic [7:0]      b1;
  logic [7:0]      b2;
  logic [31:0]     rv1;
  logic [31:0]     rv2;
  logic [AW-1:0]   ea;
  logic [23:0]     acc;
  logic [15:0]     rvalid;
  logic            rvld_q;
  logic [31:0]     regval;
  logic [31:0]     lb32;
  logic [31:0]     ea_sum;
  logic [31:0]     word;
  logic [31:0]     alu;
  logic [AW-1:0]   tgt;
  logic [AW-1:0]   pc2;
  logic [AW-1:0]   pc4;
  logic [3:0]      r1;
  logic [3:0]      r2;

  assign r1     = b1[7:4];
  assign r2     = b1[3:0];
  assign regval = rvld_q ? rrdata : 32'd0;
  assign lb32   = {8'd0, load_base};
  assign pc2    = pc + AW'(2);
  assign pc4    = pc + AW'(4);
  assign tgt    = AW'(rv2 - lb32);
  assign ea_sum = regval - lb32 + rv2 + {20'd0, b2[3:0], mrdata};
  assign word   = {acc, mrdata};

  // load, add or subtract result
  always_comb begin
    unique case (opc)
      s360x_pkg::OP_A: alu = rv1 + word;
      s360x_pkg::OP_S: alu = rv1 - word;
      default:         alu = word;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;

  // memory addressing per step
  always_comb begin
    mraddr = pc;
    rraddr = 4'd0;
    mwe    = 1'b0;
    mwaddr = clr;
    mwdata = 8'd0;
    unique case (state)
      S_CLEAR: mwe = 1'b1;
      S_IDLE: begin
        if (in_valid && !in_op) begin
          mwe    = 1'b1;
          mwaddr = AW'(in_addr);
          mwdata = in_byte;
        end
      end
      S_F0: mraddr = pc + AW'(1);
      S_F1: begin
        mraddr = pc2;
        rraddr = mrdata[3:0];
      end
      S_F2: begin
        mraddr = pc + AW'(3);
        rraddr = mrdata[7:4];
      end
      S_F3: rraddr = r1;
      S_MWR: begin
        mwe    = 1'b1;
        mwaddr = ea + AW'(cnt);
        unique case (cnt)
          2'd0:    mwdata = rv1[31:24];
          2'd1:    mwdata = rv1[23:16];
          2'd2:    mwdata = rv1[15:8];
          default: mwdata = rv1[7:0];
        endcase
      end
      S_MRD: mraddr = ea + AW'(cnt);
      default: ;
    endcase
  end

  // register file writes
  always_comb begin
    rwe    = 1'b0;
    rwaddr = r1;
    rwdata = alu;
    if (state == S_ADDR && opc == s360x_pkg::OP_BALR && r1 != 4'd0) begin
      rwe    = 1'b1;
      rwdata = lb32 + 32'(pc) + 32'd2;
    end else if (state == S_MRDL) begin
      rwe = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= 2'd0;
      pc        <= '0;
      halted    <= 1'b0;
      halt_code <= s360x_pkg::ST_OK;
      rvalid    <= '0;
      rvld_q    <= 1'b0;
    end else begin
      rvld_q <= rvalid[rraddr];
      if (rwe) begin
        rvalid[rwaddr] <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          // halted execute items repeat the halt code
          res <= {56'd0, 10'(pc), (in_op && halted) ? halt_code : s360x_pkg::ST_OK};
          if (in_valid) begin
            if (!in_op || halted) begin
              state <= S_DONE;
            end else begin
              state <= S_F0;
            end
          end
        end
        S_F0: begin
          opc   <= mrdata;
          state <= S_F1;
        end
        S_F1: begin
          b1    <= mrdata;
          state <= S_F2;
        end
        S_F2: begin
          b2    <= mrdata;
          rv2   <= regval;
          state <= S_F3;
        end
        S_F3: begin
          ea    <= AW'(ea_sum);
          state <= S_ADDR;
        end
        S_ADDR: begin
          rv1             <= regval;
          cnt             <= 2'd0;
          res.opcode_done <= opc;
          if (opc == s360x_pkg::OP_BALR) begin
            if (r1 != 4'd0) begin
              res.reg_written <= 1'b1;
              res.dest_reg    <= r1;
              res.dest_value  <= lb32 + 32'(pc) + 32'd2;
            end
            pc          <= (r2 != 4'd0) ? tgt : pc2;
            res.next_pc <= 10'((r2 != 4'd0) ? tgt : pc2);
            state       <= S_DONE;
          end else if (opc == s360x_pkg::OP_BCR) begin
            if (r1 != s360x_pkg::MASK_ALWAYS) begin
              halted     <= 1'b1;
              halt_code  <= s360x_pkg::ST_BADMASK;
              res.status <= s360x_pkg::ST_BADMASK;
            end else if (r2 == 4'd0) begin
              pc          <= pc2;
              res.next_pc <= 10'(pc2);
            end else if (rv2 == 32'd0) begin
              halted     <= 1'b1;
              halt_code  <= s360x_pkg::ST_EXIT;
              res.status <= s360x_pkg::ST_EXIT;
            end else begin
              pc          <= tgt;
              res.next_pc <= 10'(tgt);
            end
            state <= S_DONE;
          end else if (opc == s360x_pkg::OP_ST) begin
            state <= S_MWR;
          end else if (opc == s360x_pkg::OP_L || opc == s360x_pkg::OP_A ||
                       opc == s360x_pkg::OP_S) begin
            state <= S_MRD;
          end else begin
            halted     <= 1'b1;
            halt_code  <= s360x_pkg::ST_BADOP;
            res.status <= s360x_pkg::ST_BADOP;
            state      <= S_DONE;
          end
        end
        S_MWR: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            pc                    <= pc4;
            res.next_pc           <= 10'(pc4);
            res.mem_written       <= 1'b1;
            res.effective_address <= 10'(ea);
            state                 <= S_DONE;
          end
        end
        S_MRD: begin
          if (cnt != 2'd0) begin
            acc <= {acc[15:0], mrdata};
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= S_MRDL;
          end
        end
        S_MRDL: begin
          pc                    <= pc4;
          res.next_pc           <= 10'(pc4);
          res.reg_written       <= 1'b1;
          res.dest_reg          <= r1;
          res.dest_value        <= alu;
          res.effective_address <= 10'(ea);
          state                 <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "s360_subset_instruction_executor_top_assert.svh"

  `S360_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted)
  `S360_ASSERT_NOW(a_regwr_step, clk, rst, rwe, (state == S_ADDR || state == S_MRDL))
  `S360_ASSERT_NOW(a_no_accept_clear, clk, rst, in_ready, state != S_CLEAR)
  `S360_ASSERT_NOW(a_halted_no_fetch, clk, rst, state == S_F0, !halted)

endmodule
`default_nettype wire

[src/s360_subset_instruction_executor_top.sv]
`default_nettype none
// Executes a subset of System/360 instructions (BALR, BCR 15, ST, L, A, S) held in a
// byte-wide program memory of MEM_BYTES bytes. An input item with tuser 0 writes one
// memory byte; with tuser 1 it executes the instruction at the program counter. The
// byte memory has a single registered read port, so the four instruction bytes are
// read one after another, then the effective address is formed, one step executes and
// one hands the result over; ST adds four byte writes, and L, A and S add four byte
// reads and one step to write the register. Once the block has halted, execute items
// skip the fetch. A new item is taken only after the last result has been handed
// over. After reset the memory is swept to zero before the first item is taken;
// configuration writes are taken at any time. Once a halt status is reported, execute
// items repeat it until reset.
module s360_subset_instruction_executor_top #(
  parameter int MEM_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // mem_address[9:0], load_byte[17:10]
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata,   // status, next_pc, opcode_done, reg_written,
                                      // dest_reg, dest_value, mem_written,
                                      // effective_address
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data   // load_base
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [23:0]       load_base;
  logic              out_free;
  logic              res_valid;
  s360x_pkg::res_t   res;
  s360x_pkg::res_t   out_res;
  logic              mwe;
  logic [AW-1:0]     mwaddr;
  logic [7:0]        mwdata;
  logic [AW-1:0]     mraddr;
  logic [7:0]        mrdata;
  logic              rwe;
  logic [3:0]        rwaddr;
  logic [31:0]       rwdata;
  logic [3:0]        rraddr;
  logic [31:0]       rrdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {4'd0, out_res};

  // load base register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= s360x_pkg::LOAD_BASE_RESET;
    end else if (cfg_valid) begin
      load_base <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  s360x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mwe),
    .waddr (mwaddr),
    .wdata (mwdata),
    .raddr (mraddr),
    .rdata (mrdata)
  );

  s360x_ram #(.WIDTH(32), .DEPTH(16)) u_regs (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rwdata),
    .raddr (rraddr),
    .rdata (rrdata)
  );

  s360x_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_addr   (s_tdata[9:0]),
    .in_byte   (s_tdata[17:10]),
    .load_base (load_base),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mwe       (mwe),
    .mwaddr    (mwaddr),
    .mwdata    (mwdata),
    .mraddr    (mraddr),
    .mrdata    (mrdata),
    .rwe       (rwe),
    .rwaddr    (rwaddr),
    .rwdata    (rwdata),
    .rraddr    (rraddr),
    .rrdata    (rrdata)
  );

endmodule
`default_nettype wire
